/* sv/mpg_pkg.sv */
// ----------------------------------------------------------------------------
// mpg_pkg
// Shared types, constants and helpers for the mirror-pad gather engine.
// ----------------------------------------------------------------------------
package mpg_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_RANK_DEF    = 4;
    localparam int STORE_DEPTH_DEF = 4096;

    // fixed field widths
    localparam int IDX_W  = 24;
    localparam int VAL_W  = 8;
    localparam int STAT_W = 2;
    localparam int DIM_W  = 16;
    localparam int STR_W  = IDX_W + 1;
    localparam int PROD_W = STR_W + DIM_W;
    localparam int CFG_W  = 64;
    localparam int CIDX_W = 3;
    localparam int RANK_W = 3;

    // a stride at this value means "at least this large"
    localparam logic [STR_W-1:0] STRIDE_SAT = STR_W'(25'h100_0000);

    // item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ADDR  = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_PAD_MODE   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_RANK       = 3'd1;
    localparam logic [CIDX_W-1:0] REG_IN_DIMS    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_OUT_DIMS   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_PAD_BEFORE = 3'd4;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_STR_INIT,
        S_STR_OUT,
        S_STR_IN,
        S_CHECK,
        S_DIV,
        S_SUB,
        S_MIRROR,
        S_MUL,
        S_ACC,
        S_FINISH,
        S_EMIT
    } mpg_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic               str_init;
        logic               str_out;
        logic               str_in;
        logic               div_load;
        logic               div_step;
        logic               sub;
        logic               mirror;
        logic               mul;
        logic               acc;
        logic               next_dim;
        logic               mem_read;
        logic               emit;
        logic [STAT_W-1:0]  emit_status;
    } mpg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic k_zero;
        logic last_dim;
        logic div_last;
        logic over_size;
        logic err;
    } mpg_stat_t;

    // 16-bit field d of a packed dimension word, dimension 0 in the top bits
    function automatic logic [DIM_W-1:0] field16(input logic [CFG_W-1:0] pk,
                                                 input logic [1:0] d);
        logic [DIM_W-1:0] f;
        unique case (d)
            2'd0:    f = pk[63:48];
            2'd1:    f = pk[47:32];
            2'd2:    f = pk[31:16];
            default: f = pk[15:0];
        endcase
        return f;
    endfunction

    // clamp a stride product at the saturation value
    function automatic logic [STR_W-1:0] sat_stride(input logic [PROD_W-1:0] p);
        logic [STR_W-1:0] s;
        if (p > PROD_W'(STRIDE_SAT))
            s = STRIDE_SAT;
        else
            s = p[STR_W-1:0];
        return s;
    endfunction

endpackage

/* sv/mpg_ctrl.sv */
// ----------------------------------------------------------------------------
// mpg_ctrl
// Sequencer: stride rebuild after a register write, and the per-dimension
// divide / mirror / multiply / accumulate walk of a fetch item.
// ----------------------------------------------------------------------------
module mpg_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              accept,
    input  logic              opcode,
    input  logic              cfg_fire,
    input  mpg_pkg::mpg_stat_t stat,
    output mpg_pkg::mpg_cmd_t  cmd,
    output logic              busy,
    output logic              cfg_ready
);
    import mpg_pkg::*;

    mpg_state_t state_reg;
    mpg_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                    state_next = S_STR_INIT;
                else if (accept && opcode == OP_FETCH)
                    state_next = S_CHECK;
            end
            S_STR_INIT:
            begin
                cmd.str_init = 1'b1;
                state_next   = S_STR_OUT;
            end
            S_STR_OUT:
            begin
                cmd.str_out = 1'b1;
                state_next  = S_STR_IN;
            end
            S_STR_IN:
            begin
                cmd.str_in = 1'b1;
                state_next = stat.k_zero ? S_IDLE : S_STR_OUT;
            end
            S_CHECK:
            begin
                if (stat.over_size)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_RANGE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_MIRROR;
            end
            S_MIRROR:
            begin
                cmd.mirror = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.last_dim)
                    state_next = S_FINISH;
                else
                begin
                    cmd.next_dim = 1'b1;
                    cmd.div_load = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_FINISH:
            begin
                if (stat.err)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_ADDR;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STAT_OK;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a register write always starts a stride rebuild
    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> state_reg == S_STR_INIT)
        else $error("register write did not start stride rebuild");

    // an accepted fetch goes to the range check
    a_fetch_check: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_FETCH) |=> state_reg == S_CHECK)
        else $error("fetch item did not enter range check");

    // every result ends the item
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == S_IDLE)
        else $error("result issued without returning to idle");

endmodule

/* sv/mpg_datapath.sv */
// ----------------------------------------------------------------------------
// mpg_datapath
// Registers, stride table, restoring divider, mirror logic, shared
// multiplier, address accumulator, input store and result registers.
// ----------------------------------------------------------------------------
module mpg_datapath
#(
    parameter int MAX_RANK    = mpg_pkg::MAX_RANK_DEF,
    parameter int STORE_DEPTH = mpg_pkg::STORE_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               opcode,
    input  logic [mpg_pkg::IDX_W-1:0]          elem_index,
    input  logic signed [mpg_pkg::VAL_W-1:0]   elem_value,
    input  logic                               cfg_fire,
    input  logic [mpg_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [mpg_pkg::CFG_W-1:0]          cfg_data,
    input  mpg_pkg::mpg_cmd_t                  cmd,
    output mpg_pkg::mpg_stat_t                 stat,
    output logic                               done,
    output logic [mpg_pkg::IDX_W-1:0]          out_index,
    output logic signed [mpg_pkg::VAL_W-1:0]   out_value,
    output logic [mpg_pkg::STAT_W-1:0]         status
);
    import mpg_pkg::*;

    localparam int KW     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int DCNT_W = $clog2(IDX_W);
    localparam int C_W    = IDX_W + 2;

    // configuration registers
    logic               pad_mode_reg;
    logic [RANK_W-1:0]  rank_reg;
    logic [CFG_W-1:0]   in_dims_reg;
    logic [CFG_W-1:0]   out_dims_reg;
    logic [CFG_W-1:0]   pad_before_reg;

    // stride table
    logic [STR_W-1:0]   stride_o_reg [MAX_RANK];
    logic [STR_W-1:0]   stride_i_reg [MAX_RANK];
    logic [STR_W-1:0]   acc_o_reg;
    logic [STR_W-1:0]   acc_i_reg;
    logic [KW-1:0]      k_reg;

    // fetch walk
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   rem_reg;
    logic [STR_W-1:0]   pr_reg;
    logic [IDX_W-1:0]   dv_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic signed [C_W-1:0] c_reg;
    logic [DIM_W-1:0]   cm_reg;
    logic               bad_dim_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [AW:0]        addr_reg;
    logic               err_reg;

    // store and results
    logic [VAL_W-1:0]   store_mem [STORE_DEPTH];
    logic [VAL_W-1:0]   rd_data_reg;
    logic               done_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [STAT_W-1:0]  status_reg;

    // combinational helpers
    logic [RANK_W-1:0]  r_eff;
    logic [KW-1:0]      rm1;
    logic [DIM_W-1:0]   dim_o;
    logic [DIM_W-1:0]   dim_i;
    logic [DIM_W-1:0]   pad_k;
    logic [STR_W-1:0]   mul_a;
    logic [DIM_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [STR_W:0]     div_num;
    logic [STR_W:0]     div_d;
    logic               div_ge;
    logic [STR_W-1:0]   pr_next;
    logic signed [C_W-1:0] dim_s;
    logic signed [C_W-1:0] cm;
    logic               cm_bad;
    logic [AW:0]        addr_sum;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_mode_reg   <= 1'b0;
            rank_reg       <= RANK_W'(1);
            in_dims_reg    <= CFG_W'(1);
            out_dims_reg   <= CFG_W'(1);
            pad_before_reg <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_PAD_MODE:   pad_mode_reg   <= cfg_data[0];
                REG_RANK:       rank_reg       <= cfg_data[RANK_W-1:0];
                REG_IN_DIMS:    in_dims_reg    <= cfg_data;
                REG_OUT_DIMS:   out_dims_reg   <= cfg_data;
                REG_PAD_BEFORE: pad_before_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // rank in use, clamped to 1..MAX_RANK
    always_comb
    begin
        if (rank_reg == '0)
            r_eff = RANK_W'(1);
        else if (rank_reg > RANK_W'(MAX_RANK))
            r_eff = RANK_W'(MAX_RANK);
        else
            r_eff = rank_reg;
    end
    assign rm1 = KW'(r_eff - RANK_W'(1));

    // per-dimension fields
    assign dim_o = field16(out_dims_reg, 2'(k_reg));
    assign dim_i = field16(in_dims_reg, 2'(k_reg));
    assign pad_k = field16(pad_before_reg, 2'(k_reg));

    // shared multiplier: stride products on rebuild, coordinate times stride on fetch
    always_comb
    begin
        if (cmd.mul)
        begin
            mul_a = stride_i_reg[k_reg];
            mul_b = cm_reg;
        end
        else if (cmd.str_in)
        begin
            mul_a = acc_i_reg;
            mul_b = dim_i;
        end
        else
        begin
            mul_a = acc_o_reg;
            mul_b = dim_o;
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // stride table rebuild, innermost dimension first
    // reset sizes put dimension 0 at zero, so the running products start at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_RANK; j++)
            begin
                stride_o_reg[j] <= '0;
                stride_i_reg[j] <= '0;
            end
            stride_o_reg[0] <= STR_W'(1);
            stride_i_reg[0] <= STR_W'(1);
            acc_o_reg       <= '0;
            acc_i_reg       <= '0;
        end
        else if (cmd.str_init)
        begin
            for (int j = 0; j < MAX_RANK; j++)
            begin
                stride_o_reg[j] <= '0;
                stride_i_reg[j] <= '0;
            end
            acc_o_reg <= STR_W'(1);
            acc_i_reg <= STR_W'(1);
        end
        else if (cmd.str_out)
        begin
            stride_o_reg[k_reg] <= acc_o_reg;
            acc_o_reg           <= sat_stride(mul_p);
        end
        else if (cmd.str_in)
        begin
            stride_i_reg[k_reg] <= acc_i_reg;
            acc_i_reg           <= sat_stride(mul_p);
        end
    end

    // dimension counter: down on rebuild, up on fetch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= '0;
        else if (cmd.str_init)
            k_reg <= rm1;
        else if (cmd.str_in && k_reg != '0)
            k_reg <= k_reg - KW'(1);
        else if (accept)
            k_reg <= '0;
        else if (cmd.next_dim)
            k_reg <= k_reg + KW'(1);
    end

    // restoring divider step: remainder by current output stride
    assign div_num = {pr_reg, dv_reg[IDX_W-1]};
    assign div_d   = {1'b0, stride_o_reg[k_reg]};
    assign div_ge  = (div_num >= div_d);
    assign pr_next = div_ge ? STR_W'(div_num - div_d) : div_num[STR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_load)
            div_cnt_reg <= '0;
        else if (cmd.div_step && !stat.div_last)
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= elem_index;
            rem_reg <= elem_index;
        end
        else if (cmd.div_step && stat.div_last)
        begin
            rem_reg <= pr_next[IDX_W-1:0];
        end

        if (cmd.div_load)
        begin
            pr_reg <= '0;
            dv_reg <= rem_reg;
        end
        else if (cmd.div_step)
        begin
            pr_reg <= pr_next;
            dv_reg <= {dv_reg[IDX_W-2:0], div_ge};
        end
    end

    // mirror the coordinate back into the input dimension
    assign dim_s = $signed(C_W'(dim_i));

    always_comb
    begin
        if (c_reg < 0)
        begin
            if (pad_mode_reg)
                cm = -c_reg - C_W'(1);
            else
                cm = -c_reg;
        end
        else if (c_reg >= dim_s)
        begin
            if (pad_mode_reg)
                cm = dim_s + dim_s - C_W'(1) - c_reg;
            else
                cm = dim_s + dim_s - C_W'(2) - c_reg;
        end
        else
        begin
            cm = c_reg;
        end
        cm_bad = (cm < 0) || (cm >= dim_s);
    end

    // coordinate, mirror and product stages
    always_ff @(posedge clk)
    begin
        if (cmd.sub)
            c_reg <= $signed(C_W'(dv_reg)) - $signed(C_W'(pad_k));
        if (cmd.mirror)
        begin
            cm_reg      <= cm[DIM_W-1:0];
            bad_dim_reg <= cm_bad;
        end
        if (cmd.mul)
            prod_reg <= mul_p;
    end

    // input address accumulation with range flag
    assign addr_sum = addr_reg + prod_reg[AW:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (accept)
        begin
            addr_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (bad_dim_reg || prod_reg >= PROD_W'(STORE_DEPTH)
                || addr_sum >= (AW+1)'(STORE_DEPTH))
                err_reg <= 1'b1;
            else
                addr_reg <= addr_sum;
        end
    end

    // input store
    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_LOAD && elem_index < IDX_W'(STORE_DEPTH))
            store_mem[elem_index[AW-1:0]] <= elem_value;
        if (cmd.mem_read)
            rd_data_reg <= store_mem[addr_reg[AW-1:0]];
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_index_reg <= idx_reg;
            status_reg    <= cmd.emit_status;
            out_value_reg <= (cmd.emit_status == STAT_OK) ? rd_data_reg : '0;
        end
    end

    // status to controller
    assign stat.k_zero    = (k_reg == '0);
    assign stat.last_dim  = (k_reg == rm1);
    assign stat.div_last  = (div_cnt_reg == DCNT_W'(IDX_W - 1));
    assign stat.over_size = ({1'b0, idx_reg} >= acc_o_reg);
    assign stat.err       = err_reg;

    assign done      = done_reg;
    assign out_index = out_index_reg;
    assign out_value = $signed(out_value_reg);
    assign status    = status_reg;

    // error results carry a zero byte
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != STAT_OK) |-> out_value_reg == '0)
        else $error("error result with nonzero value");

    // a clean address stays inside the store
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        !err_reg |-> addr_reg < (AW+1)'(STORE_DEPTH))
        else $error("accumulated address outside store without error flag");

    // divider step count stays within the index width
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        div_cnt_reg < DCNT_W'(IDX_W))
        else $error("divider step count overrun");

endmodule

/* sv/mirror_pad_gather_core.sv */
// Load item: written to the store at the accept edge if its index is in range, no result.
// Fetch item: range check, then for each dimension the divider, subtract, mirror,
// multiply and accumulate steps, then the store read and the result; the next item
// can be accepted while done is high. Past output size or a mirrored address outside
// the store: error result, no read. Register write: stride rebuild with busy high.
// Async reset clears control and registers, store undefined until written; no result stall.
// ----------------------------------------------------------------------------
// mirror_pad_gather_core
// Mirror-pad gather engine for signed byte tensors: loads fill the input
// store, fetches return the reflect or symmetric padded byte with status.
// ----------------------------------------------------------------------------
module mirror_pad_gather_core
#(
    parameter int MAX_RANK    = mpg_pkg::MAX_RANK_DEF,
    parameter int STORE_DEPTH = mpg_pkg::STORE_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic [mpg_pkg::IDX_W-1:0]          elem_index,
    input  logic signed [mpg_pkg::VAL_W-1:0]   elem_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpg_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [mpg_pkg::CFG_W-1:0]          cfg_data,
    output logic                               done,
    output logic [mpg_pkg::IDX_W-1:0]          out_index,
    output logic signed [mpg_pkg::VAL_W-1:0]   out_value,
    output logic [mpg_pkg::STAT_W-1:0]         status
);
    import mpg_pkg::*;

    logic      accept;
    logic      cfg_fire;
    mpg_cmd_t  cmd;
    mpg_stat_t stat;

    // handshakes
    assign accept   = start && !busy;
    assign cfg_fire = cfg_valid && cfg_ready;

    // sequencer
    mpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .accept    (accept),
        .opcode    (opcode),
        .cfg_fire  (cfg_fire),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready)
    );

    // datapath and store
    mpg_datapath
    #(
        .MAX_RANK    (MAX_RANK),
        .STORE_DEPTH (STORE_DEPTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .elem_index (elem_index),
        .elem_value (elem_value),
        .cfg_fire   (cfg_fire),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .out_index  (out_index),
        .out_value  (out_value),
        .status     (status)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mirror-pad gather core: loads fill the input
// store, fetches are predicted in reflect and symmetric mode over several
// register settings and compared field by field with the returned items.
// ----------------------------------------------------------------------------
module testbench;

    import mpg_pkg::*;

    // slowest fetch at full rank, plus margin
    localparam int FETCH_LATENCY_MAX = 4 + 28 * MAX_RANK_DEF + 8;
    localparam int CYCLE_LIMIT       = 2_000_000;
    localparam int RANDOM_SETTINGS   = 12;
    localparam int ITEMS_PER_SETTING = 140;
    localparam int GAP_MAX           = 8;

    // first register index past the defined ones
    localparam logic [CIDX_W-1:0] REG_UNUSED_LO = REG_PAD_BEFORE + 3'd1;

    // one returned item
    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
        logic [STAT_W-1:0]       stat;
    } padded_byte_t;

    // one full register setting
    typedef struct {
        logic              mode;
        logic [RANK_W-1:0] rank;
        logic [CFG_W-1:0]  in_dims;
        logic [CFG_W-1:0]  out_dims;
        logic [CFG_W-1:0]  pads;
    } pad_setup_t;

    // ------------------------------------------------------------------------
    // mirror-pad predictor and store of awaited fetch items
    // ------------------------------------------------------------------------
    class mirror_pad_book;

        logic                    pad_sym;
        logic [RANK_W-1:0]       rank_reg;
        logic [CFG_W-1:0]        in_dims;
        logic [CFG_W-1:0]        out_dims;
        logic [CFG_W-1:0]        pads;
        longint unsigned         out_stride[4];
        longint unsigned         in_stride[4];
        logic signed [VAL_W-1:0] store_bytes[STORE_DEPTH_DEF];
        bit                      written[STORE_DEPTH_DEF];
        padded_byte_t            awaited_bytes[$];
        int unsigned             failures;
        int unsigned             loads;
        int unsigned             settings;
        int unsigned             by_status[3];

        function new();
            pad_sym   = 1'b0;
            rank_reg  = RANK_W'(1);
            in_dims   = 64'd1;
            out_dims  = 64'd1;
            pads      = '0;
            failures  = 0;
            loads     = 0;
            settings  = 0;
            by_status = '{default: 0};
            foreach (written[a])
                written[a] = 1'b0;
            rebuild_strides();
        endfunction

        // dimension 0 sits in the top 16 bits
        function logic [DIM_W-1:0] dim_field(logic [CFG_W-1:0] w, int k);
            return w[CFG_W - 1 - DIM_W * k -: DIM_W];
        endfunction

        // rank codes outside 1..MAX_RANK clamp
        function int live_rank();
            if (rank_reg == 0)
                return 1;
            if (rank_reg > MAX_RANK_DEF)
                return MAX_RANK_DEF;
            return int'(rank_reg);
        endfunction

        // row-major strides, saturated at the index range
        function void rebuild_strides();
            longint unsigned so;
            longint unsigned si;
            int k;
            so = 1;
            si = 1;
            for (k = 0; k < 4; k++)
            begin
                out_stride[k] = 0;
                in_stride[k]  = 0;
            end
            for (k = live_rank() - 1; k >= 0; k--)
            begin
                out_stride[k] = so;
                in_stride[k]  = si;
                so = so * dim_field(out_dims, k);
                si = si * dim_field(in_dims, k);
                if (so > longint'(STRIDE_SAT))
                    so = longint'(STRIDE_SAT);
                if (si > longint'(STRIDE_SAT))
                    si = longint'(STRIDE_SAT);
            end
        endfunction

        function void apply_reg(logic [CIDX_W-1:0] ridx, logic [CFG_W-1:0] data);
            case (ridx)
                REG_PAD_MODE:   pad_sym  = data[0];
                REG_RANK:       rank_reg = data[RANK_W-1:0];
                REG_IN_DIMS:    in_dims  = data;
                REG_OUT_DIMS:   out_dims = data;
                REG_PAD_BEFORE: pads     = data;
                default:        return;
            endcase
            rebuild_strides();
        endfunction

        function longint unsigned out_volume();
            longint unsigned n;
            int k;
            n = 1;
            for (k = 0; k < live_rank(); k++)
                n = n * dim_field(out_dims, k);
            return n;
        endfunction

        // map an output index back into the input store
        function logic [STAT_W-1:0] mirror_fetch(logic [IDX_W-1:0] idx, output int addr);
            longint unsigned rem;
            longint c;
            longint d;
            longint acc;
            logic fault;
            int k;
            addr  = 0;
            rem   = idx;
            acc   = 0;
            fault = 1'b0;
            if (idx >= out_volume())
                return STAT_RANGE;
            for (k = 0; k < live_rank(); k++)
            begin
                d = longint'(dim_field(in_dims, k));
                c = longint'(rem / out_stride[k]) - longint'(dim_field(pads, k));
                rem = rem % out_stride[k];
                // fold back across the near or far edge
                if (c < 0)
                    c = pad_sym ? -c - 1 : -c;
                else if (c >= d)
                    c = pad_sym ? 2 * d - 1 - c : 2 * (d - 1) - c;
                if (c < 0 || c >= d)
                    fault = 1'b1;
                else
                    acc += c * longint'(in_stride[k]);
            end
            if (fault || acc >= STORE_DEPTH_DEF)
                return STAT_ADDR;
            addr = int'(acc);
            return STAT_OK;
        endfunction

        function void note_item(logic op, logic [IDX_W-1:0] idx,
                                logic signed [VAL_W-1:0] val);
            padded_byte_t r;
            int addr;
            if (op == OP_LOAD)
            begin
                loads++;
                if (idx < STORE_DEPTH_DEF)
                begin
                    store_bytes[idx] = val;
                    written[idx]     = 1'b1;
                end
                return;
            end
            r.idx  = idx;
            r.stat = mirror_fetch(idx, addr);
            r.val  = (r.stat == STAT_OK) ? store_bytes[addr] : '0;
            by_status[r.stat]++;
            awaited_bytes.push_back(r);
        endfunction

        function void complain(string msg);
            failures++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
                                   logic [STAT_W-1:0] stat);
            padded_byte_t want;
            if (awaited_bytes.size() == 0)
            begin
                complain($sformatf("item with none awaited: index %0h value %0d status %0d",
                                   idx, val, stat));
                return;
            end
            want = awaited_bytes.pop_front();
            if (idx !== want.idx)
                complain($sformatf("out_index expected %0h actual %0h", want.idx, idx));
            if (val !== want.val)
                complain($sformatf("out_value at %0h expected %0d actual %0d",
                                   want.idx, want.val, val));
            if (stat !== want.stat)
                complain($sformatf("status at %0h expected %0d actual %0d",
                                   want.idx, want.stat, stat));
        endfunction

        function int pending();
            return awaited_bytes.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // signals and block
    // ------------------------------------------------------------------------
    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    start      = 1'b0;
    logic                    opcode     = OP_LOAD;
    logic [IDX_W-1:0]        elem_index = '0;
    logic signed [VAL_W-1:0] elem_value = '0;
    logic                    cfg_valid  = 1'b0;
    logic [CIDX_W-1:0]       cfg_index  = REG_PAD_MODE;
    logic [CFG_W-1:0]        cfg_data   = '0;
    logic                    busy;
    logic                    cfg_ready;
    logic                    done;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic [STAT_W-1:0]       status;

    mirror_pad_book book;
    int unsigned    sender_idle_pct = 0;
    int unsigned    cycle_count;

    mirror_pad_gather_core DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .elem_index (elem_index),
        .elem_value (elem_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .out_index  (out_index),
        .out_value  (out_value),
        .status     (status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_result(out_index, out_value, status);
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run stopped after %0d cycles with %0d items awaited",
                 $time, CYCLE_LIMIT, book.pending());
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // hold start low until every fetch has answered and the block settles
    task automatic wait_quiet();
        start <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (FETCH_LATENCY_MAX) @(posedge clk);
    endtask

    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] val);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99, 0) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        elem_index <= idx;
        elem_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        book.note_item(op, idx, val);
    endtask

    task automatic fetch_item(input logic [IDX_W-1:0] idx);
        int addr;
        // a fetch only ever reaches store entries that hold a loaded byte
        if (book.mirror_fetch(idx, addr) == STAT_OK && !book.written[addr])
            send_item(OP_LOAD, IDX_W'(addr), VAL_W'($urandom));
        send_item(OP_FETCH, idx, VAL_W'($urandom));
    endtask

    // cfg_valid stays high across back-to-back writes
    task automatic write_reg(input logic [CIDX_W-1:0] ridx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= ridx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.apply_reg(ridx, data);
    endtask

    // narrow registers get random upper bits
    task automatic set_config(input pad_setup_t s, input bit with_unused);
        wait_quiet();
        write_reg(REG_PAD_MODE, ({$urandom, $urandom} << 1) | CFG_W'(s.mode));
        write_reg(REG_RANK, ({$urandom, $urandom} << RANK_W) | CFG_W'(s.rank));
        write_reg(REG_IN_DIMS, s.in_dims);
        write_reg(REG_OUT_DIMS, s.out_dims);
        write_reg(REG_PAD_BEFORE, s.pads);
        if (with_unused)
            write_reg(REG_UNUSED_LO + CIDX_W'($urandom_range(2, 0)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
        book.settings++;
    endtask

    // well-formed pad geometry in the live dims, junk above the rank
    function automatic pad_setup_t random_setup();
        pad_setup_t s;
        int r;
        int k;
        int d;
        int pb;
        int pa;
        int d_max;
        s.mode = 1'($urandom_range(1, 0));
        r      = $urandom_range(MAX_RANK_DEF, 1);
        s.rank = RANK_W'(r);
        // out-of-range rank codes that select the same live rank
        if ($urandom_range(4, 0) == 0)
        begin
            if (r == 1)
                s.rank = '0;
            else if (r == MAX_RANK_DEF)
                s.rank = RANK_W'($urandom_range(7, MAX_RANK_DEF + 1));
        end
        s.in_dims  = {$urandom, $urandom};
        s.out_dims = {$urandom, $urandom};
        s.pads     = {$urandom, $urandom};
        d_max      = (r <= 2) ? 16 : 8;
        for (k = 0; k < r; k++)
        begin
            d  = $urandom_range(d_max, 1);
            pb = $urandom_range(d - 1 + s.mode, 0);
            pa = $urandom_range(d - 1 + s.mode, 0);
            // oversized leading pad sends some fetches outside the input
            if ($urandom_range(9, 0) == 0)
                pb = d + $urandom_range(3, 0);
            s.in_dims[CFG_W - 1 - DIM_W * k -: DIM_W]  = DIM_W'(d);
            s.pads[CFG_W - 1 - DIM_W * k -: DIM_W]     = DIM_W'(pb);
            s.out_dims[CFG_W - 1 - DIM_W * k -: DIM_W] = DIM_W'(d + pb + pa);
        end
        return s;
    endfunction

    task automatic random_item();
        int unsigned pick;
        longint unsigned span;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99, 0);
        span = book.out_volume();
        // occasional full drain mid-stream
        if (pick == 0)
            wait_quiet();
        if (pick < 15)
            send_item(OP_LOAD, IDX_W'($urandom_range(STORE_DEPTH_DEF - 1, 0)), VAL_W'($urandom));
        else if (pick < 20)
            send_item(OP_LOAD, IDX_W'($urandom), VAL_W'($urandom));
        else
        begin
            if (span == 0 || span >= (64'd1 << IDX_W))
                idx = IDX_W'($urandom);
            else if (pick < 30)
                idx = ($urandom_range(1, 0) == 0) ? IDX_W'(span + $urandom_range(3, 0))
                                                  : IDX_W'($urandom);
            else
                idx = IDX_W'($urandom_range(32'(span - 1), 0));
            fetch_item(idx);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pad_setup_t s;
        int ph;
        book            = new();
        sender_idle_pct = 29;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reflect over 3x4 padded to 7x10, store edge loads, stray register index
        s.mode     = 1'b0;
        s.rank     = RANK_W'(2);
        s.in_dims  = {16'd3, 16'd4, 32'h0};
        s.out_dims = {16'd7, 16'd10, 32'h0};
        s.pads     = {16'd2, 16'd3, 32'h0};
        set_config(s, 1'b1);
        send_item(OP_LOAD, IDX_W'(STORE_DEPTH_DEF - 1), 8'h7F);
        send_item(OP_LOAD, IDX_W'(STORE_DEPTH_DEF), 8'h80);
        send_item(OP_LOAD, '1, 8'hFF);
        send_item(OP_LOAD, '0, 8'h80);
        fetch_item(IDX_W'(0));
        fetch_item(IDX_W'(69));
        fetch_item(IDX_W'(70));
        fetch_item('1);
        fetch_item(IDX_W'(35));

        // symmetric with rank code zero, pad equal to the dim
        s.mode     = 1'b1;
        s.rank     = '0;
        s.in_dims  = {16'd5, 48'h0};
        s.out_dims = {16'd15, 48'h0};
        s.pads     = {16'd5, 48'h0};
        set_config(s, 1'b0);
        fetch_item(IDX_W'(0));
        fetch_item(IDX_W'(14));
        fetch_item(IDX_W'(7));

        // rank code above the limit, every dim at its maximum, saturated strides
        s.mode     = 1'b0;
        s.rank     = '1;
        s.in_dims  = '1;
        s.out_dims = '1;
        s.pads     = '0;
        set_config(s, 1'b0);
        fetch_item(IDX_W'(0));
        fetch_item('1);

        // zero-sized input dim
        s.rank     = RANK_W'(1);
        s.in_dims  = {16'd0, 48'h1234_5678_9ABC};
        s.out_dims = {16'd3, 48'h0};
        s.pads     = {16'd1, 48'h0};
        set_config(s, 1'b0);
        fetch_item(IDX_W'(1));
        fetch_item(IDX_W'(0));

        // zero-sized output dim
        s.mode     = 1'b1;
        s.rank     = RANK_W'(2);
        s.in_dims  = {16'd4, 16'd4, 32'h0};
        s.out_dims = {16'd4, 16'd0, 32'h0};
        s.pads     = '0;
        set_config(s, 1'b0);
        fetch_item(IDX_W'(0));

        // random settings, sender idling light then heavy then none
        for (ph = 0; ph < RANDOM_SETTINGS; ph++)
        begin
            sender_idle_pct = (ph < 4) ? 29 : (ph < 8) ? 54 : 0;
            s = random_setup();
            // all sizes and pads at their maximum
            if (ph == RANDOM_SETTINGS - 2)
            begin
                s.mode     = 1'b1;
                s.rank     = RANK_W'(MAX_RANK_DEF);
                s.in_dims  = '1;
                s.out_dims = '1;
                s.pads     = '1;
            end
            set_config(s, 1'b0);
            repeat (ITEMS_PER_SETTING) random_item();
        end

        wait_quiet();
        $display("covered %0d loads and %0d fetches over %0d register settings",
                 book.loads,
                 book.by_status[STAT_OK] + book.by_status[STAT_RANGE] + book.by_status[STAT_ADDR],
                 book.settings);
        $display("fetch outcomes: %0d read, %0d past output size, %0d outside input",
                 book.by_status[STAT_OK], book.by_status[STAT_RANGE], book.by_status[STAT_ADDR]);
        if (book.failures == 0 && book.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
